### rtl/tapos_pkg.sv
// ----------------------------------------------------------------------------
// tapos_pkg: shared constants for the two-anchor position solver
// Field widths, register reset value and output saturation limits.
// ----------------------------------------------------------------------------
package tapos_pkg;

   localparam int BASE_BITS     = 10;
   localparam int DIV_BITS      = BASE_BITS + 1;   // divisor is 2 * baseline
   localparam int X_BITS        = 20;
   localparam int Y_BITS        = 10;
   localparam int DIST_BITS_DEF = 10;

   localparam logic [BASE_BITS-1:0] BASELINE_RST = BASE_BITS'(10);

   localparam logic [X_BITS-1:0] X_POS_MAX = {1'b0, {(X_BITS-1){1'b1}}};
   localparam logic [X_BITS-1:0] X_NEG_MIN = {1'b1, {(X_BITS-1){1'b0}}};
   localparam logic [Y_BITS-1:0] Y_MAX     = {Y_BITS{1'b1}};

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

### rtl/tapos_div_cell.sv
// ----------------------------------------------------------------------------
// tapos_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, trial-subtracts the
// divisor and shifts the quotient bit in at the bottom of the dividend word.
// ----------------------------------------------------------------------------
module tapos_div_cell #(
   parameter int MAG_BITS  = 21,
   parameter int SIDE_BITS = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [tapos_pkg::DIV_BITS-1:0] in_rem,
   input  logic [MAG_BITS-1:0]           in_dq,
   input  logic [SIDE_BITS-1:0]          in_side,
   input  logic [tapos_pkg::DIV_BITS-1:0] divisor,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [tapos_pkg::DIV_BITS-1:0] out_rem,
   output logic [MAG_BITS-1:0]           out_dq,
   output logic [SIDE_BITS-1:0]          out_side
);
   import tapos_pkg::*;

   logic                 valid_ff;
   logic [DIV_BITS-1:0]  rem_ff, rem_in;
   logic [MAG_BITS-1:0]  dq_ff, dq_in;
   logic [SIDE_BITS-1:0] side_ff;
   logic [DIV_BITS:0]    trial;
   logic                 fits;

   always_comb begin
      trial = {in_rem, in_dq[MAG_BITS-1]};
      fits  = (trial >= {1'b0, divisor});
      if (fits) begin
         rem_in = DIV_BITS'(trial - {1'b0, divisor});
      end else begin
         rem_in = trial[DIV_BITS-1:0];
      end
      dq_in = {in_dq[MAG_BITS-2:0], fits};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff  <= rem_in;
         dq_ff   <= dq_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_dq    = dq_ff;
   assign out_side  = side_ff;

endmodule

### rtl/tapos_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tapos_sqrt_cell: one digit step of the integer square root
// Brings down two radicand bits, tries root*4+1 and settles one root bit.
// ----------------------------------------------------------------------------
module tapos_sqrt_cell #(
   parameter int ROOT_BITS = 10,
   parameter int SIDE_BITS = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [ROOT_BITS+1:0]   in_rem,
   input  logic [ROOT_BITS-1:0]   in_root,
   input  logic [2*ROOT_BITS-1:0] in_rad,
   input  logic [SIDE_BITS-1:0]   in_side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [ROOT_BITS+1:0]   out_rem,
   output logic [ROOT_BITS-1:0]   out_root,
   output logic [2*ROOT_BITS-1:0] out_rad,
   output logic [SIDE_BITS-1:0]   out_side
);
   logic                   valid_ff;
   logic [ROOT_BITS+1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [2*ROOT_BITS-1:0] rad_ff, rad_in;
   logic [SIDE_BITS-1:0]   side_ff;
   logic [ROOT_BITS+3:0]   shifted, trial;
   logic                   fits;

   always_comb begin
      shifted = {in_rem, in_rad[2*ROOT_BITS-1 -: 2]};
      trial   = {2'b00, in_root, 2'b01};
      fits    = (shifted >= trial);
      if (fits) begin
         rem_in = (ROOT_BITS+2)'(shifted - trial);
      end else begin
         rem_in = shifted[ROOT_BITS+1:0];
      end
      root_in = {in_root[ROOT_BITS-2:0], fits};
      rad_in  = {in_rad[2*ROOT_BITS-3:0], 2'b00};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_rad   = rad_ff;
   assign out_side  = side_ff;

endmodule

### rtl/two_anchor_position_solver.sv
// ----------------------------------------------------------------------------
// two_anchor_position_solver: bilateration from two anchor distances
// Anchors sit at (0,0) and (baseline,0). For every distance pair the block
// returns x = (d1^2 + b^2 - d2^2) / (2b), truncated toward zero, and y =
// floor(sqrt(d1^2 - x^2)), or a no-solution flag if the circles miss or b = 0.
//
// Usage:
//  - req_* : one transaction per node (two distances and a last-node mark).
//  - rsp_* : one transaction per node, in arrival order.
//  - csr_* : write the baseline; csr_ready is always high. Write it only
//            while no node is in flight.
//  - A node passes the square and numerator registers, the divider chain
//    (one quotient bit per cell), the x-check and radicand registers, the
//    root chain (one root bit per cell) and the output register. MAG_BITS,
//    the numerator magnitude width, is max(2*DIST_BITS, 20) + 1.
//  - Throughput is one node per cycle while rsp_ready stays high: every stage
//    holds a transaction and takes a new one whenever it is empty or its neighbor takes its content.
//  - When rsp_ready is low, hold the result and fill empty stages; once all
//    stages are full, drop req_ready.
//  - Reset empties the pipeline and sets the baseline to 10.
// ----------------------------------------------------------------------------
module two_anchor_position_solver #(
   parameter int DIST_BITS = tapos_pkg::DIST_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [DIST_BITS-1:0]                req_dist_near,
   input  logic [DIST_BITS-1:0]                req_dist_far,
   input  logic                                req_last_node,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tapos_pkg::X_BITS-1:0] rsp_pos_x,
   output logic [tapos_pkg::Y_BITS-1:0]        rsp_pos_y,
   output logic                                rsp_no_solution,
   output logic                                rsp_last_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tapos_pkg::BASE_BITS-1:0]     csr_baseline
);
   import tapos_pkg::*;

   // Magnitude of the numerator; it also bounds the quotient magnitude.
   localparam int SQ_BITS   = 2 * DIST_BITS;
   localparam int MAG_BITS  = max_int(SQ_BITS, 2 * BASE_BITS) + 1;
   localparam int DSIDE     = SQ_BITS + DIST_BITS + 2;   // last, neg, d1^2, d1
   localparam int RSIDE     = X_BITS + 2;                // last, none, x
   localparam int YW        = max_int(DIST_BITS, Y_BITS);

   // ------------------------------------------------------------------------
   // Baseline register
   // ------------------------------------------------------------------------
   logic [BASE_BITS-1:0] baseline_ff;
   logic [DIV_BITS-1:0]  divisor;
   logic                 base_zero;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff <= BASELINE_RST;
      end else if (csr_valid && csr_ready) begin
         baseline_ff <= csr_baseline;
      end
   end

   assign divisor   = {baseline_ff, 1'b0};
   assign base_zero = (baseline_ff == '0);

   // ------------------------------------------------------------------------
   // Stage 1: squares of both distances and of the baseline
   // ------------------------------------------------------------------------
   logic                     pwr_v_ff;
   logic                     pwr_ready;
   logic [DIST_BITS-1:0]     pwr_d1_ff;
   logic [SQ_BITS-1:0]       pwr_d1sq_ff, pwr_d1sq_in;
   logic [SQ_BITS-1:0]       pwr_d2sq_ff, pwr_d2sq_in;
   logic [2*BASE_BITS-1:0]   pwr_bsq_ff, pwr_bsq_in;
   logic                     pwr_last_ff;
   logic                     num_ready;

   assign pwr_ready = !pwr_v_ff || num_ready;
   assign req_ready = pwr_ready;

   always_comb begin
      pwr_d1sq_in = SQ_BITS'(req_dist_near) * SQ_BITS'(req_dist_near);
      pwr_d2sq_in = SQ_BITS'(req_dist_far) * SQ_BITS'(req_dist_far);
      pwr_bsq_in  = (2*BASE_BITS)'(baseline_ff) * (2*BASE_BITS)'(baseline_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwr_v_ff <= 1'b0;
      end else if (pwr_ready) begin
         pwr_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && pwr_ready) begin
         pwr_d1_ff   <= req_dist_near;
         pwr_d1sq_ff <= pwr_d1sq_in;
         pwr_d2sq_ff <= pwr_d2sq_in;
         pwr_bsq_ff  <= pwr_bsq_in;
         pwr_last_ff <= req_last_node;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: numerator, split into sign and magnitude for the divider
   // ------------------------------------------------------------------------
   logic                 num_v_ff;
   logic [MAG_BITS-1:0]  num_mag_ff, num_mag_in;
   logic                 num_neg_ff, num_neg_in;
   logic [DIST_BITS-1:0] num_d1_ff;
   logic [SQ_BITS-1:0]   num_d1sq_ff;
   logic                 num_last_ff;
   logic [MAG_BITS:0]    num_wide;

   logic                div_v   [0:MAG_BITS];
   logic                div_r   [0:MAG_BITS];
   logic [DIV_BITS-1:0] div_rem [0:MAG_BITS];
   logic [MAG_BITS-1:0] div_dq  [0:MAG_BITS];
   logic [DSIDE-1:0]    div_side[0:MAG_BITS];

   assign num_ready = !num_v_ff || div_r[0];

   always_comb begin
      num_wide = (MAG_BITS+1)'(pwr_d1sq_ff) + (MAG_BITS+1)'(pwr_bsq_ff)
               - (MAG_BITS+1)'(pwr_d2sq_ff);
      num_neg_in = num_wide[MAG_BITS];
      if (num_neg_in) begin
         num_mag_in = MAG_BITS'((MAG_BITS+1)'(0) - num_wide);
      end else begin
         num_mag_in = num_wide[MAG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_v_ff <= 1'b0;
      end else if (num_ready) begin
         num_v_ff <= pwr_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pwr_v_ff && num_ready) begin
         num_mag_ff  <= num_mag_in;
         num_neg_ff  <= num_neg_in;
         num_d1_ff   <= pwr_d1_ff;
         num_d1sq_ff <= pwr_d1sq_ff;
         num_last_ff <= pwr_last_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Divider chain: one quotient bit per cell, MSB first
   // ------------------------------------------------------------------------
   assign div_v[0]    = num_v_ff;
   assign div_rem[0]  = '0;
   assign div_dq[0]   = num_mag_ff;
   assign div_side[0] = {num_last_ff, num_neg_ff, num_d1sq_ff, num_d1_ff};

   for (genvar i = 0; i < MAG_BITS; i++) begin : g_div
      tapos_div_cell #(
         .MAG_BITS (MAG_BITS),
         .SIDE_BITS(DSIDE)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (div_v[i]),
         .in_ready (div_r[i]),
         .in_rem   (div_rem[i]),
         .in_dq    (div_dq[i]),
         .in_side  (div_side[i]),
         .divisor  (divisor),
         .out_valid(div_v[i+1]),
         .out_ready(div_r[i+1]),
         .out_rem  (div_rem[i+1]),
         .out_dq   (div_dq[i+1]),
         .out_side (div_side[i+1])
      );
   end

   // ------------------------------------------------------------------------
   // Stage 3: signed, saturated x and the no-solution check
   // ------------------------------------------------------------------------
   logic                 chk_v_ff;
   logic                 chk_ready;
   logic [X_BITS-1:0]    chk_x_ff, chk_x_in;
   logic                 chk_none_ff, chk_none_in;
   logic [DIST_BITS-1:0] chk_ax_ff, chk_ax_in;
   logic [SQ_BITS-1:0]   chk_d1sq_ff;
   logic                 chk_last_ff;
   logic [MAG_BITS-1:0]  quo;
   logic                 quo_neg;
   logic [SQ_BITS-1:0]   quo_d1sq;
   logic [DIST_BITS-1:0] quo_d1;
   logic                 quo_last;
   logic                 rad_ready;

   assign div_r[MAG_BITS] = chk_ready;
   assign chk_ready       = !chk_v_ff || rad_ready;
   assign quo             = div_dq[MAG_BITS];
   assign {quo_last, quo_neg, quo_d1sq, quo_d1} = div_side[MAG_BITS];

   always_comb begin
      chk_none_in = base_zero || (quo > MAG_BITS'(quo_d1));
      chk_ax_in   = chk_none_in ? '0 : quo[DIST_BITS-1:0];
      if (base_zero) begin
         chk_x_in = '0;
      end else if (!quo_neg) begin
         chk_x_in = (quo > MAG_BITS'(X_POS_MAX)) ? X_POS_MAX : quo[X_BITS-1:0];
      end else if (quo > MAG_BITS'(X_NEG_MIN)) begin
         chk_x_in = X_NEG_MIN;
      end else begin
         chk_x_in = X_BITS'(0) - quo[X_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_v_ff <= 1'b0;
      end else if (chk_ready) begin
         chk_v_ff <= div_v[MAG_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (div_v[MAG_BITS] && chk_ready) begin
         chk_x_ff    <= chk_x_in;
         chk_none_ff <= chk_none_in;
         chk_ax_ff   <= chk_ax_in;
         chk_d1sq_ff <= quo_d1sq;
         chk_last_ff <= quo_last;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: radicand d1^2 - x^2 (x forced to zero when there is no root)
   // ------------------------------------------------------------------------
   logic                 rad_v_ff;
   logic [SQ_BITS-1:0]   rad_val_ff, rad_val_in;
   logic [X_BITS-1:0]    rad_x_ff;
   logic                 rad_none_ff;
   logic                 rad_last_ff;

   logic                   rt_v   [0:DIST_BITS];
   logic                   rt_r   [0:DIST_BITS];
   logic [DIST_BITS+1:0]   rt_rem [0:DIST_BITS];
   logic [DIST_BITS-1:0]   rt_root[0:DIST_BITS];
   logic [SQ_BITS-1:0]     rt_rad [0:DIST_BITS];
   logic [RSIDE-1:0]       rt_side[0:DIST_BITS];

   assign rad_ready  = !rad_v_ff || rt_r[0];
   assign rad_val_in = chk_d1sq_ff - SQ_BITS'(chk_ax_ff) * SQ_BITS'(chk_ax_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rad_v_ff <= 1'b0;
      end else if (rad_ready) begin
         rad_v_ff <= chk_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (chk_v_ff && rad_ready) begin
         rad_val_ff  <= rad_val_in;
         rad_x_ff    <= chk_x_ff;
         rad_none_ff <= chk_none_ff;
         rad_last_ff <= chk_last_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Root chain: one root bit per cell, MSB first
   // ------------------------------------------------------------------------
   assign rt_v[0]    = rad_v_ff;
   assign rt_rem[0]  = '0;
   assign rt_root[0] = '0;
   assign rt_rad[0]  = rad_val_ff;
   assign rt_side[0] = {rad_last_ff, rad_none_ff, rad_x_ff};

   for (genvar j = 0; j < DIST_BITS; j++) begin : g_root
      tapos_sqrt_cell #(
         .ROOT_BITS(DIST_BITS),
         .SIDE_BITS(RSIDE)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (rt_v[j]),
         .in_ready (rt_r[j]),
         .in_rem   (rt_rem[j]),
         .in_root  (rt_root[j]),
         .in_rad   (rt_rad[j]),
         .in_side  (rt_side[j]),
         .out_valid(rt_v[j+1]),
         .out_ready(rt_r[j+1]),
         .out_rem  (rt_rem[j+1]),
         .out_root (rt_root[j+1]),
         .out_rad  (rt_rad[j+1]),
         .out_side (rt_side[j+1])
      );
   end

   // ------------------------------------------------------------------------
   // Output register: saturate y, zero it when there is no solution
   // ------------------------------------------------------------------------
   logic              out_v_ff;
   logic              out_ready;
   logic [X_BITS-1:0] out_x_ff;
   logic [Y_BITS-1:0] out_y_ff, out_y_in;
   logic              out_none_ff;
   logic              out_last_ff;
   logic [YW-1:0]     root_ext;
   logic [X_BITS-1:0] fin_x;
   logic              fin_none;
   logic              fin_last;

   assign out_ready         = !out_v_ff || rsp_ready;
   assign rt_r[DIST_BITS]   = out_ready;
   assign {fin_last, fin_none, fin_x} = rt_side[DIST_BITS];
   assign root_ext          = YW'(rt_root[DIST_BITS]);

   always_comb begin
      if (fin_none) begin
         out_y_in = '0;
      end else if (root_ext > YW'(Y_MAX)) begin
         out_y_in = Y_MAX;
      end else begin
         out_y_in = root_ext[Y_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_ready) begin
         out_v_ff <= rt_v[DIST_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (rt_v[DIST_BITS] && out_ready) begin
         out_x_ff    <= fin_x;
         out_y_ff    <= out_y_in;
         out_none_ff <= fin_none;
         out_last_ff <= fin_last;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_pos_x       = $signed(out_x_ff);
   assign rsp_pos_y       = out_y_ff;
   assign rsp_no_solution = out_none_ff;
   assign rsp_last_out    = out_last_ff;

endmodule
